// ===== rtl/edfs_pkg.sv =====
// ----------------------------------------------------------------------------
// edfs_pkg: shared types and constants of the edf periodic task scheduler
// per-slot memory entry layouts, slot evaluation result and controller states
// ----------------------------------------------------------------------------
package edfs_pkg;

   localparam int MAX_TASKS_DEF = 8;

   localparam int TASK_COUNT_W = 4;
   localparam int TASK_INDEX_W = 3;
   localparam int WORD_W       = 16;
   localparam int TIME_W       = 32;

   localparam logic [TIME_W-1:0] KEY_BIAS = 32'h8000_0000;

   // dynamic per-slot job state, reads as zero until first written
   typedef struct packed {
      logic [WORD_W-1:0] phase;
      logic [WORD_W-1:0] remaining;
      logic [TIME_W-1:0] deadline;
   } job_entry_type;

   // static per-slot task parameters
   typedef struct packed {
      logic [WORD_W-1:0] burst;
      logic [WORD_W-1:0] rel_deadline;
      logic [WORD_W-1:0] period;
   } param_entry_type;

   // one slot after release, with its urgency key and next phase
   typedef struct packed {
      logic              has_work;
      logic [TIME_W-1:0] key;
      logic [WORD_W-1:0] phase_next;
      logic [WORD_W-1:0] remaining;
      logic [TIME_W-1:0] deadline;
   } slot_eval_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } sched_state_type;

endpackage

// ===== rtl/edf_periodic_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler: earliest-deadline-first periodic task scheduler
// per-slot state in two single-port-read memories, scanned one slot a cycle
// ----------------------------------------------------------------------------
// usage
//   request channel: a transaction is taken at a clock edge with start high
//   and busy low. req_mode 1 loads one slot (burst, relative deadline, period)
//   and clears its job; it is done in that cycle and gives no result.
//   req_mode 0 is one time tick and gives exactly one result.
//   result channel: rsp_strobe is high for one cycle with rsp_idle,
//   rsp_running_task and rsp_tick_time; the receiver cannot stall it.
//   csr channel: csr_task_count sets the number of active slots; csr_ready is
//   always high; write it only while busy is low.
// scan
//   a tick scans the active slots in order with one job/param memory read
//   per slot, the read of slot i+1 overlapping the write-back of slot i;
//   then the done state writes the chosen slot's decremented work and
//   shows the result.
// reset
//   synchronous; time, task count and all job state go to zero, the task
//   parameter tables stay unknown until loaded.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler #(
   parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic [edfs_pkg::TASK_INDEX_W-1:0]   req_task_index,
   input  logic [edfs_pkg::WORD_W-1:0]         req_burst_length,
   input  logic [edfs_pkg::WORD_W-1:0]         req_relative_deadline,
   input  logic [edfs_pkg::WORD_W-1:0]         req_task_period,
   // result channel
   output logic                                rsp_strobe,
   output logic                                rsp_idle,
   output logic [edfs_pkg::TASK_INDEX_W-1:0]   rsp_running_task,
   output logic [edfs_pkg::TIME_W-1:0]         rsp_tick_time,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [edfs_pkg::TASK_COUNT_W-1:0]   csr_task_count
);
   import edfs_pkg::*;

   localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam logic [6:0] MAX7 = 7'(MAX_TASKS);

   // state
   sched_state_type   state_ff, state_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TASK_COUNT_W-1:0] task_count_ff;
   logic [CNT_W-1:0]  n_ff, n_in;           // active slots latched for this tick
   logic [CNT_W-1:0]  cur_ff, cur_in;       // slot whose read data is present
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] pick_ff, pick_in;
   logic [TIME_W-1:0] best_key_ff, best_key_in;
   logic [WORD_W-1:0] best_phase_ff, best_phase_in;
   logic [WORD_W-1:0] best_rem_ff, best_rem_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;

   // memory ports
   logic              job_wr_en;
   logic [SLOT_W-1:0] job_wr_addr;
   job_entry_type     job_wr_data;
   job_entry_type     job_rd_data;
   logic              par_wr_en;
   logic [SLOT_W-1:0] rd_addr;
   param_entry_type   par_wr_data;
   param_entry_type   par_rd_data;
   slot_eval_type     slot;

   // helpers
   logic              accept;
   logic [6:0]        index7;
   logic [6:0]        count7;
   logic [CNT_W-1:0]  cur_next;
   logic [6:0]        pick7;
   logic [SLOT_W-1:0] load_addr;

   edfs_job_mem #(
      .DEPTH  (MAX_TASKS),
      .ADDR_W (SLOT_W)
   ) u_job_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr_en),
      .wr_addr (job_wr_addr),
      .wr_data (job_wr_data),
      .rd_addr (rd_addr),
      .rd_data (job_rd_data)
   );

   edfs_param_mem #(
      .DEPTH  (MAX_TASKS),
      .ADDR_W (SLOT_W)
   ) u_param_mem (
      .clock   (clock),
      .wr_en   (par_wr_en),
      .wr_addr (load_addr),
      .wr_data (par_wr_data),
      .rd_addr (rd_addr),
      .rd_data (par_rd_data)
   );

   edfs_slot_eval u_slot_eval (
      .job    (job_rd_data),
      .param  (par_rd_data),
      .now    (time_ff),
      .result (slot)
   );

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         task_count_ff <= csr_task_count;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign index7    = 7'(req_task_index);
   assign load_addr = index7[SLOT_W-1:0];
   assign count7    = 7'(task_count_ff);
   assign cur_next  = cur_ff + CNT_W'(1);
   assign pick7     = 7'(pick_ff);

   assign par_wr_data.burst        = req_burst_length;
   assign par_wr_data.rel_deadline = req_relative_deadline;
   assign par_wr_data.period       = req_task_period;

   // controller: next state, scan bookkeeping and memory port control
   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      n_in          = n_ff;
      cur_in        = cur_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_key_in   = best_key_ff;
      best_phase_in = best_phase_ff;
      best_rem_in   = best_rem_ff;
      best_dl_in    = best_dl_ff;

      job_wr_en   = 1'b0;
      job_wr_addr = load_addr;
      job_wr_data = '0;
      par_wr_en   = 1'b0;
      rd_addr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  // load: slots beyond the table are dropped
                  if (index7 < MAX7) begin
                     par_wr_en = 1'b1;
                     job_wr_en = 1'b1;
                  end
               end else begin
                  n_in     = (count7 > MAX7) ? CNT_W'(MAX_TASKS) : count7[CNT_W-1:0];
                  cur_in   = '0;
                  found_in = 1'b0;
                  pick_in  = '0;
                  // slot 0 read issued here, data present next cycle
                  state_in = (n_in == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // write back the released job and advanced phase of this slot
            job_wr_en   = 1'b1;
            job_wr_addr = cur_ff[SLOT_W-1:0];
            job_wr_data.phase     = slot.phase_next;
            job_wr_data.remaining = slot.remaining;
            job_wr_data.deadline  = slot.deadline;

            if (slot.has_work && (!found_ff || (slot.key < best_key_ff))) begin
               found_in      = 1'b1;
               pick_in       = cur_ff[SLOT_W-1:0];
               best_key_in   = slot.key;
               best_phase_in = slot.phase_next;
               best_rem_in   = slot.remaining;
               best_dl_in    = slot.deadline;
            end

            rd_addr = cur_next[SLOT_W-1:0];
            cur_in  = cur_next;
            if (cur_next == n_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // the chosen slot runs one tick
            if (found_ff) begin
               job_wr_en   = 1'b1;
               job_wr_addr = pick_ff;
               job_wr_data.phase     = best_phase_ff;
               job_wr_data.remaining = best_rem_ff - 16'd1;
               job_wr_data.deadline  = best_dl_ff;
            end
            time_in  = time_ff + 32'd1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         time_ff  <= '0;
         n_ff     <= '0;
         cur_ff   <= '0;
         found_ff <= 1'b0;
         pick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
         n_ff     <= n_in;
         cur_ff   <= cur_in;
         found_ff <= found_in;
         pick_ff  <= pick_in;
      end
   end

   // best-candidate payload
   always_ff @(posedge clock) begin
      best_key_ff   <= best_key_in;
      best_phase_ff <= best_phase_in;
      best_rem_ff   <= best_rem_in;
      best_dl_ff    <= best_dl_in;
   end

   // result transaction shown in the write-back cycle
   assign rsp_strobe       = (state_ff == ST_DONE);
   assign rsp_idle         = !found_ff;
   assign rsp_running_task = found_ff ? pick7[TASK_INDEX_W-1:0] : '0;
   assign rsp_tick_time    = time_ff;

endmodule

// ===== rtl/edfs_job_mem.sv =====
// ----------------------------------------------------------------------------
// edfs_job_mem: per-slot job state memory
// one write and one registered read port; per-entry valid bits make
// never-written entries read as zero after reset
// ----------------------------------------------------------------------------
module edfs_job_mem #(
   parameter int DEPTH  = edfs_pkg::MAX_TASKS_DEF,
   parameter int ADDR_W = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  edfs_pkg::job_entry_type wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output edfs_pkg::job_entry_type rd_data
);
   import edfs_pkg::*;

   job_entry_type mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   job_entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/edfs_param_mem.sv =====
// ----------------------------------------------------------------------------
// edfs_param_mem: per-slot task parameter memory
// burst, relative deadline and period; one write, one registered read port
// ----------------------------------------------------------------------------
module edfs_param_mem #(
   parameter int DEPTH  = edfs_pkg::MAX_TASKS_DEF,
   parameter int ADDR_W = 3
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  edfs_pkg::param_entry_type wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output edfs_pkg::param_entry_type rd_data
);
   import edfs_pkg::*;

   param_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/edfs_slot_eval.sv =====
// ----------------------------------------------------------------------------
// edfs_slot_eval: release and urgency of one slot
// applies a job release at phase zero, forms the biased deadline key and
// the advanced period phase
// ----------------------------------------------------------------------------
module edfs_slot_eval (
   input  edfs_pkg::job_entry_type                  job,
   input  edfs_pkg::param_entry_type                param,
   input  logic [edfs_pkg::TIME_W-1:0]              now,
   output edfs_pkg::slot_eval_type                  result
);
   import edfs_pkg::*;

   logic              released;
   logic [TIME_W-1:0] distance;
   logic [WORD_W:0]   phase_inc;

   always_comb begin
      released  = (job.phase == '0);
      phase_inc = {1'b0, job.phase} + 17'd1;

      result.remaining = released ? param.burst : job.remaining;
      result.deadline  = released ? (now + {16'b0, param.rel_deadline}) : job.deadline;
      // on release the distance to the deadline is the relative deadline itself
      distance         = released ? {16'b0, param.rel_deadline} : (job.deadline - now);
      result.key       = distance ^ KEY_BIAS;
      result.has_work  = (result.remaining != '0);
      // period of zero behaves as period of one
      result.phase_next = (phase_inc >= {1'b0, param.period}) ? '0 : phase_inc[WORD_W-1:0];
   end

endmodule

// ===== tb/sv/edf_periodic_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_tb: self-checking bench of the edf scheduler
// loads task sets, sweeps the active slot count, issues ticks with random
// gaps and compares every result strobe against an in-bench edf predictor
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int        SLOTS        = edfs_pkg::MAX_TASKS_DEF;
   localparam bit        MODE_TICK    = 1'b0;
   localparam bit        MODE_LOAD    = 1'b1;
   localparam bit [31:0] URGENCY_BIAS = 32'h8000_0000;
   // covers the longest tick, a scan of all SLOTS slots, with margin
   localparam int        SETTLE_CYCLES = 16;

   // one expected tick outcome
   typedef struct {
      bit        idle;
      bit [2:0]  task_id;
      bit [31:0] tick_time;
   } tick_result_type;

   // edf predictor plus queue of tick outcomes still to arrive
   class sched_scoreboard;
      bit [3:0]        slot_count;
      bit [31:0]       now_time;
      bit [15:0]       phase_cnt  [SLOTS];
      bit [15:0]       work_left  [SLOTS];
      bit [31:0]       due_time   [SLOTS];
      bit [15:0]       burst_tab  [SLOTS];
      bit [15:0]       dline_tab  [SLOTS];
      bit [15:0]       period_tab [SLOTS];
      tick_result_type expected_ticks [$];
      int              error_count;

      function void set_slot_count(bit [3:0] value);
         slot_count = value;
      endfunction

      function void note_request(bit mode, bit [2:0] slot, bit [15:0] burst,
                                 bit [15:0] rel_dl, bit [15:0] period);
         int              active;
         int              i;
         int              pick;
         bit              found;
         bit [31:0]       best;
         bit [31:0]       key;
         bit [16:0]       next_phase;
         tick_result_type res;
         if (mode == MODE_LOAD) begin
            burst_tab[slot]  = burst;
            dline_tab[slot]  = rel_dl;
            period_tab[slot] = period;
            work_left[slot]  = 16'd0;
            phase_cnt[slot]  = 16'd0;
            return;
         end
         active = (slot_count > SLOTS) ? SLOTS : int'(slot_count);
         // release jobs whose phase wrapped to zero
         for (i = 0; i < active; i++) begin
            if (phase_cnt[i] == 16'd0) begin
               work_left[i] = burst_tab[i];
               due_time[i]  = now_time + {16'd0, dline_tab[i]};
            end
         end
         // earliest deadline by signed distance, lowest index wins ties
         found = 1'b0;
         pick  = 0;
         best  = 32'd0;
         for (i = 0; i < active; i++) begin
            if (work_left[i] != 16'd0) begin
               key = (due_time[i] - now_time) ^ URGENCY_BIAS;
               if (!found || key < best) begin
                  found = 1'b1;
                  best  = key;
                  pick  = i;
               end
            end
         end
         if (found)
            work_left[pick] = work_left[pick] - 16'd1;
         res.idle      = !found;
         res.task_id   = found ? 3'(pick) : 3'd0;
         res.tick_time = now_time;
         expected_ticks.push_back(res);
         // period zero behaves like period one here as well
         for (i = 0; i < active; i++) begin
            next_phase   = {1'b0, phase_cnt[i]} + 17'd1;
            phase_cnt[i] = (next_phase >= {1'b0, period_tab[i]}) ? 16'd0 : next_phase[15:0];
         end
         now_time = now_time + 32'd1;
      endfunction

      function void check_result(bit idle, bit [2:0] task_id, bit [31:0] tick_time);
         tick_result_type want;
         if (expected_ticks.size() == 0) begin
            $error("unexpected result: idle %0d running_task %0d tick_time %0d",
                   idle, task_id, tick_time);
            error_count++;
            return;
         end
         want = expected_ticks.pop_front();
         if (idle !== want.idle) begin
            $error("idle: expected %0d, actual %0d", want.idle, idle);
            error_count++;
         end
         if (task_id !== want.task_id) begin
            $error("running_task: expected %0d, actual %0d", want.task_id, task_id);
            error_count++;
         end
         if (tick_time !== want.tick_time) begin
            $error("tick_time: expected %0d, actual %0d", want.tick_time, tick_time);
            error_count++;
         end
      endfunction

      function void report_leftover();
         if (expected_ticks.size() != 0) begin
            $error("%0d expected results never arrived", expected_ticks.size());
            error_count += expected_ticks.size();
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_mode;
   logic [2:0]  req_task_index;
   logic [15:0] req_burst_length;
   logic [15:0] req_relative_deadline;
   logic [15:0] req_task_period;
   logic        rsp_strobe;
   logic        rsp_idle;
   logic [2:0]  rsp_running_task;
   logic [31:0] rsp_tick_time;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_task_count;

   sched_scoreboard sb = new;

   edf_periodic_task_scheduler #(
      .MAX_TASKS(SLOTS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_mode              (req_mode),
      .req_task_index        (req_task_index),
      .req_burst_length      (req_burst_length),
      .req_relative_deadline (req_relative_deadline),
      .req_task_period       (req_task_period),
      .rsp_strobe            (rsp_strobe),
      .rsp_idle              (rsp_idle),
      .rsp_running_task      (rsp_running_task),
      .rsp_tick_time         (rsp_tick_time),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_task_count        (csr_task_count)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   // result monitor, the strobe lasts exactly one cycle and cannot be stalled
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         sb.check_result(rsp_idle, rsp_running_task, rsp_tick_time);
   end

   // drive one transaction from a falling edge and hold it until taken;
   // start stays high on return, the next task call decides what follows
   task automatic send_request(input bit mode, input bit [2:0] slot, input bit [15:0] burst,
                               input bit [15:0] rel_dl, input bit [15:0] period);
      @(negedge clock);
      start                 = 1'b1;
      req_mode              = mode;
      req_task_index        = slot;
      req_burst_length      = burst;
      req_relative_deadline = rel_dl;
      req_task_period       = period;
      do @(posedge clock); while (busy);
      sb.note_request(mode, slot, burst, rel_dl, period);
   endtask

   // tick with random content on the ignored fields
   task automatic send_tick();
      send_request(MODE_TICK, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom));
   endtask

   // mostly small task parameters so jobs overlap, now and then full range
   task automatic send_random_load(input bit [2:0] slot);
      bit [15:0] burst;
      bit [15:0] rel_dl;
      bit [15:0] period;
      if ($urandom_range(0, 9) == 0) begin
         burst  = 16'($urandom);
         rel_dl = 16'($urandom);
         period = 16'($urandom);
      end else begin
         burst  = 16'($urandom_range(0, 5));
         rel_dl = 16'($urandom_range(0, 24));
         period = 16'($urandom_range(0, 16));
      end
      send_request(MODE_LOAD, slot, burst, rel_dl, period);
   endtask

   // sender gap
   task automatic pause_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // hold off the sender until every outstanding tick has reported
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (sb.expected_ticks.size() != 0)
         @(posedge clock);
   endtask

   // csr write only once the block is quiet, a trailing load may still be in flight
   task automatic write_task_count(input bit [3:0] value);
      drain_results();
      pause_cycles(SETTLE_CYCLES);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      csr_valid      = 1'b1;
      csr_task_count = value;
      do @(posedge clock); while (!csr_ready);
      sb.set_slot_count(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one random phase: fresh task set, then ticks mixed with reloads
   task automatic run_phase(input bit [3:0] count, input int items, input bit calm);
      int squeeze_at;
      int k;
      write_task_count(count);
      for (k = 0; k < SLOTS; k++)
         send_random_load(3'(k));
      squeeze_at = $urandom_range(10, items - SLOTS - 1);
      for (k = SLOTS; k < items; k++) begin
         // gaps come in bursts, with quiet stretches in between
         if (!calm && (k % 40) < 30 && $urandom_range(0, 3) == 0)
            pause_cycles($urandom_range(1, 14));
         if (k == squeeze_at)
            drain_results();
         if ($urandom_range(0, 99) < 15)
            send_random_load(3'($urandom_range(0, 7)));
         else
            send_tick();
      end
   endtask

   initial begin
      bit [3:0] phase_counts [8];
      int       p;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_mode              = MODE_TICK;
      req_task_index        = 3'd0;
      req_burst_length      = 16'd0;
      req_relative_deadline = 16'd0;
      req_task_period       = 16'd0;
      csr_valid             = 1'b0;
      csr_task_count        = 4'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: no active slots, the tick just reports idle
      send_tick();

      // fill every slot before any tick can read one
      send_request(MODE_LOAD, 3'd0, 16'd0, 16'd5, 16'd0);             // zero burst, zero period
      send_request(MODE_LOAD, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);    // field maxima
      send_request(MODE_LOAD, 3'd2, 16'd2, 16'd0, 16'd3);             // deadline at release
      send_request(MODE_LOAD, 3'd3, 16'd1, 16'd4, 16'd1);
      send_request(MODE_LOAD, 3'd4, 16'd3, 16'd4, 16'd6);             // ties with slot 3
      send_request(MODE_LOAD, 3'd5, 16'd1, 16'd10, 16'd4);
      send_request(MODE_LOAD, 3'd6, 16'd2, 16'd10, 16'd4);
      send_request(MODE_LOAD, 3'd7, 16'd1, 16'd2, 16'd2);

      // all slots active, overdue jobs and deadline ties show up here
      write_task_count(4'd8);
      repeat (10) send_tick();

      // a reload wipes the unfinished long job in slot 1
      send_request(MODE_LOAD, 3'd1, 16'd2, 16'd1, 16'd5);
      repeat (2) send_tick();

      // random phases, counts above the slot limit clamp to all slots
      phase_counts = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd5, 4'd0, 4'd9, 4'd0};
      phase_counts[7] = 4'($urandom_range(0, 15));
      for (p = 0; p < 8; p++)
         run_phase(phase_counts[p], 66, p == 7);

      // wind down and let any late strobe show up
      drain_results();
      pause_cycles(SETTLE_CYCLES + 4);
      sb.report_leftover();
      if (sb.error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
